// ===== src/c65ex_pkg.sv =====
// Package for the 6502 execute core: operation codes, status bit positions,
// transfer payload structs and the register file struct. No dependencies.
package c65ex_pkg;

	typedef enum logic [5:0] {
		OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
		OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
		OP_BPL = 6'd8,  OP_BVC = 6'd9,  OP_BVS = 6'd10, OP_CLC = 6'd11,
		OP_CLD = 6'd12, OP_CLI = 6'd13, OP_CLV = 6'd14, OP_CMP = 6'd15,
		OP_CPX = 6'd16, OP_CPY = 6'd17, OP_DEC = 6'd18, OP_DEX = 6'd19,
		OP_DEY = 6'd20, OP_EOR = 6'd21, OP_INC = 6'd22, OP_INX = 6'd23,
		OP_INY = 6'd24, OP_LDA = 6'd25, OP_LDX = 6'd26, OP_LDY = 6'd27,
		OP_LSR = 6'd28, OP_NOP = 6'd29, OP_ORA = 6'd30, OP_ROL = 6'd31,
		OP_ROR = 6'd32, OP_SBC = 6'd33, OP_SEC = 6'd34, OP_SED = 6'd35,
		OP_SEI = 6'd36, OP_STA = 6'd37, OP_STX = 6'd38, OP_STY = 6'd39,
		OP_TAX = 6'd40, OP_TAY = 6'd41, OP_TSX = 6'd42, OP_TXA = 6'd43,
		OP_TXS = 6'd44, OP_TYA = 6'd45
	} op_t;

	localparam int unsigned FLAG_C = 0;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_I = 2;
	localparam int unsigned FLAG_D = 3;
	localparam int unsigned FLAG_B = 4;
	localparam int unsigned FLAG_U = 5;
	localparam int unsigned FLAG_V = 6;
	localparam int unsigned FLAG_N = 7;

	localparam logic [7:0] SP_RESET     = 8'hFD;
	localparam logic [7:0] STATUS_RESET = 8'h24;

	typedef struct packed {
		logic [5:0] kind;
		logic [7:0] operand;
	} in_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic       write_back;
		logic       branch_taken;
		logic [7:0] accumulator;
		logic [7:0] index_x;
		logic [7:0] index_y;
		logic [7:0] stack_pointer;
		logic [7:0] status_flags;
	} out_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] p;
	} regs_t;

endpackage

// ===== src/c65ex_alu.sv =====
// Combinational execute logic: next register file, write-back byte and branch
// decision for one operation. Depends on c65ex_pkg.
module c65ex_alu
	import c65ex_pkg::*;
(
	input  logic [5:0] kind,
	input  logic [7:0] operand,
	input  regs_t      cur,
	output regs_t      nxt,
	output logic [7:0] result_byte,
	output logic       write_back,
	output logic       branch_taken
);

	function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] v);
		logic [7:0] r;
		r = p;
		r[FLAG_N] = v[7];
		r[FLAG_Z] = (v == 8'd0);
		return r;
	endfunction

	logic [7:0] addend;
	logic [8:0] sum;
	logic [7:0] cmp_reg;
	logic [8:0] cmp_diff;
	logic [7:0] p_cmp;

	assign addend   = (kind == OP_SBC) ? ~operand : operand;
	assign sum      = {1'b0, cur.a} + {1'b0, addend} + {8'd0, cur.p[FLAG_C]};
	assign cmp_reg  = (kind == OP_CPX) ? cur.x : ((kind == OP_CPY) ? cur.y : cur.a);
	assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

	always_comb begin
		p_cmp          = cur.p;
		p_cmp[FLAG_C]  = ~cmp_diff[8];
		p_cmp[FLAG_Z]  = (cmp_reg == operand);
		p_cmp[FLAG_N]  = cmp_diff[7];
	end

	always_comb begin
		nxt          = cur;
		result_byte  = 8'd0;
		write_back   = 1'b0;
		branch_taken = 1'b0;
		unique case (kind)
			OP_ADC, OP_SBC: begin
				nxt.a = sum[7:0];
				nxt.p = with_nz(cur.p, sum[7:0]);
				nxt.p[FLAG_C] = sum[8];
				nxt.p[FLAG_V] = ~(cur.a[7] ^ addend[7]) & (cur.a[7] ^ sum[7]);
			end
			OP_AND: begin
				nxt.a = cur.a & operand;
				nxt.p = with_nz(cur.p, cur.a & operand);
			end
			OP_ORA: begin
				nxt.a = cur.a | operand;
				nxt.p = with_nz(cur.p, cur.a | operand);
			end
			OP_EOR: begin
				nxt.a = cur.a ^ operand;
				nxt.p = with_nz(cur.p, cur.a ^ operand);
			end
			OP_ASL: begin
				result_byte = {operand[6:0], 1'b0};
				write_back  = 1'b1;
				nxt.p = with_nz(cur.p, {operand[6:0], 1'b0});
				nxt.p[FLAG_C] = operand[7];
			end
			OP_LSR: begin
				result_byte = {1'b0, operand[7:1]};
				write_back  = 1'b1;
				nxt.p = with_nz(cur.p, {1'b0, operand[7:1]});
				nxt.p[FLAG_C] = operand[0];
			end
			OP_ROL: begin
				result_byte = {operand[6:0], cur.p[FLAG_C]};
				write_back  = 1'b1;
				nxt.p = with_nz(cur.p, {operand[6:0], cur.p[FLAG_C]});
				nxt.p[FLAG_C] = operand[7];
			end
			OP_ROR: begin
				result_byte = {cur.p[FLAG_C], operand[7:1]};
				write_back  = 1'b1;
				nxt.p = with_nz(cur.p, {cur.p[FLAG_C], operand[7:1]});
				nxt.p[FLAG_C] = operand[0];
			end
			OP_BCC: branch_taken = ~cur.p[FLAG_C];
			OP_BCS: branch_taken = cur.p[FLAG_C];
			OP_BEQ: branch_taken = cur.p[FLAG_Z];
			OP_BMI: branch_taken = cur.p[FLAG_N];
			OP_BPL: branch_taken = ~cur.p[FLAG_N];
			OP_BVC: branch_taken = ~cur.p[FLAG_V];
			OP_BVS: branch_taken = cur.p[FLAG_V];
			OP_BIT: begin
				nxt.p[FLAG_N] = operand[7];
				nxt.p[FLAG_V] = operand[6];
				nxt.p[FLAG_Z] = ((cur.a & operand) == 8'd0);
			end
			OP_CLC: nxt.p[FLAG_C] = 1'b0;
			OP_CLD: nxt.p[FLAG_D] = 1'b0;
			OP_CLI: nxt.p[FLAG_I] = 1'b0;
			OP_CLV: nxt.p[FLAG_V] = 1'b0;
			OP_SEC: nxt.p[FLAG_C] = 1'b1;
			OP_SED: nxt.p[FLAG_D] = 1'b1;
			OP_SEI: nxt.p[FLAG_I] = 1'b1;
			OP_CMP, OP_CPX, OP_CPY: nxt.p = p_cmp;
			OP_DEC: begin
				result_byte = operand - 8'd1;
				write_back  = 1'b1;
				nxt.p = with_nz(cur.p, operand - 8'd1);
			end
			OP_INC: begin
				result_byte = operand + 8'd1;
				write_back  = 1'b1;
				nxt.p = with_nz(cur.p, operand + 8'd1);
			end
			OP_DEX: begin
				nxt.x = cur.x - 8'd1;
				nxt.p = with_nz(cur.p, cur.x - 8'd1);
			end
			OP_DEY: begin
				nxt.y = cur.y - 8'd1;
				nxt.p = with_nz(cur.p, cur.y - 8'd1);
			end
			OP_INX: begin
				nxt.x = cur.x + 8'd1;
				nxt.p = with_nz(cur.p, cur.x + 8'd1);
			end
			OP_INY: begin
				nxt.y = cur.y + 8'd1;
				nxt.p = with_nz(cur.p, cur.y + 8'd1);
			end
			OP_LDA: begin
				nxt.a = operand;
				nxt.p = with_nz(cur.p, operand);
			end
			OP_LDX: begin
				nxt.x = operand;
				nxt.p = with_nz(cur.p, operand);
			end
			OP_LDY: begin
				nxt.y = operand;
				nxt.p = with_nz(cur.p, operand);
			end
			OP_STA: begin
				result_byte = cur.a;
				write_back  = 1'b1;
			end
			OP_STX: begin
				result_byte = cur.x;
				write_back  = 1'b1;
			end
			OP_STY: begin
				result_byte = cur.y;
				write_back  = 1'b1;
			end
			OP_TAX: begin
				nxt.x = cur.a;
				nxt.p = with_nz(cur.p, cur.a);
			end
			OP_TAY: begin
				nxt.y = cur.a;
				nxt.p = with_nz(cur.p, cur.a);
			end
			OP_TSX: begin
				nxt.x = cur.sp;
				nxt.p = with_nz(cur.p, cur.sp);
			end
			OP_TXA: begin
				nxt.a = cur.x;
				nxt.p = with_nz(cur.p, cur.x);
			end
			OP_TYA: begin
				nxt.a = cur.y;
				nxt.p = with_nz(cur.p, cur.y);
			end
			OP_TXS: nxt.sp = cur.x;
			default: ;
		endcase
	end

endmodule

// ===== src/cpu6502_alu_execute_core.sv =====
// 6502 execute core: one operation per cycle through an input register and a
// result register. Each result passes through the input register and then the
// result register before it is offered on the output; the architectural
// registers A, X, Y, SP and P update as the operation moves from the input
// register to the result register, so the next operation sees them.
// The input register refills while a result waits, and only a stalled result
// with a full input register holds off the next transfer. Depends on c65ex_pkg.
module cpu6502_alu_execute_core
	import c65ex_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic       valid_s1;
	in_t        data_s1;
	logic       valid_s2;
	out_t       data_s2;
	regs_t      regs_q;
	regs_t      regs_nxt;
	logic [7:0] res_byte;
	logic       res_wb;
	logic       res_br;
	logic       advance;

	assign advance  = ~valid_s2 | out_ready;
	assign in_ready = ~valid_s1 | advance;

	c65ex_alu u_alu (
		.kind         (data_s1.kind),
		.operand      (data_s1.operand),
		.cur          (regs_q),
		.nxt          (regs_nxt),
		.result_byte  (res_byte),
		.write_back   (res_wb),
		.branch_taken (res_br)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			regs_q.a  <= 8'd0;
			regs_q.x  <= 8'd0;
			regs_q.y  <= 8'd0;
			regs_q.sp <= SP_RESET;
			regs_q.p  <= STATUS_RESET;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				regs_q <= regs_nxt;
			end
		end
	end

	// advance the result register with the transfer out of the input register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_s2.result_byte   <= res_byte;
			data_s2.write_back    <= res_wb;
			data_s2.branch_taken  <= res_br;
			data_s2.accumulator   <= regs_nxt.a;
			data_s2.index_x       <= regs_nxt.x;
			data_s2.index_y       <= regs_nxt.y;
			data_s2.stack_pointer <= regs_nxt.sp;
			data_s2.status_flags  <= regs_nxt.p;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

`ifndef SYNTH
	a_fixed_bits: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q.p[FLAG_U] && !regs_q.p[FLAG_B])
		else $error("status bits 5 and 4 changed");

	a_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_back |-> out_data.result_byte == 8'd0)
		else $error("result byte set without write-back");

	a_br_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.branch_taken |-> !out_data.write_back)
		else $error("branch taken with write-back");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input held off without a stalled result");
`endif

endmodule

// ===== tb/sv/tb_cpu6502_alu_execute_core.sv =====
// Self-checking testbench for cpu6502_alu_execute_core: a directed table, then random
// operations under three idling patterns; typed rows are checked against table values,
// the rest against a behavioural register model. Depends on c65ex_pkg and the core itself.
module tb_cpu6502_alu_execute_core;
	import c65ex_pkg::*;

	localparam logic [5:0] KIND_SPARE_LOW  = 6'd46;
	localparam logic [5:0] KIND_SPARE_HIGH = 6'd63;

	typedef struct packed {
		in_t  item;
		logic typed;
		out_t want;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	regs_t arch;
	out_t  pending_results[$];
	int    send_idle_pct;
	int    recv_idle_pct;
	int    hold_left;
	int    failures;
	int    ops_sent;
	int    results_seen;
	int    branches_taken;
	int    writes_back;

	dir_row_t directed_rows[$] = '{
		'{'{OP_NOP, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h24}},
		'{'{OP_LDA, 8'hFF}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'hFF, 8'h00, 8'h00, 8'hFD, 8'hA4}},
		'{'{OP_LDA, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h26}},
		'{'{OP_BEQ, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h26}},
		'{'{OP_SEC, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h27}},
		'{'{OP_ADC, 8'hFF}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h27}},
		'{'{OP_STA, 8'h5A}, 1'b1, '{8'h00, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h27}},
		'{'{OP_LDX, 8'hFF}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h00, 8'hFD, 8'hA5}},
		'{'{OP_INX, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFD, 8'h27}},
		'{'{OP_DEX, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h00, 8'hFD, 8'hA5}},
		'{'{OP_LDY, 8'h80}, 1'b0, '0},
		'{'{OP_INY, 8'h00}, 1'b0, '0},
		'{'{OP_DEY, 8'h00}, 1'b0, '0},
		'{'{OP_LDA, 8'h7F}, 1'b0, '0},
		'{'{OP_ADC, 8'h01}, 1'b0, '0},
		'{'{OP_SBC, 8'h80}, 1'b0, '0},
		'{'{OP_CMP, 8'h80}, 1'b0, '0},
		'{'{OP_CPX, 8'h00}, 1'b0, '0},
		'{'{OP_CPY, 8'hFF}, 1'b0, '0},
		'{'{OP_ASL, 8'h80}, 1'b0, '0},
		'{'{OP_LSR, 8'h01}, 1'b0, '0},
		'{'{OP_ROL, 8'hFF}, 1'b0, '0},
		'{'{OP_ROR, 8'h00}, 1'b0, '0},
		'{'{OP_BIT, 8'hC0}, 1'b0, '0},
		'{'{OP_BMI, 8'h00}, 1'b0, '0},
		'{'{OP_BPL, 8'h00}, 1'b0, '0},
		'{'{OP_BVS, 8'h00}, 1'b0, '0},
		'{'{OP_CLV, 8'h00}, 1'b0, '0},
		'{'{OP_BVC, 8'h00}, 1'b0, '0},
		'{'{OP_BCC, 8'h00}, 1'b0, '0},
		'{'{OP_BCS, 8'h00}, 1'b0, '0},
		'{'{OP_CLC, 8'h00}, 1'b0, '0},
		'{'{OP_CLI, 8'h00}, 1'b0, '0},
		'{'{OP_SEI, 8'h00}, 1'b0, '0},
		'{'{OP_SED, 8'h00}, 1'b0, '0},
		'{'{OP_ADC, 8'h80}, 1'b0, '0},
		'{'{OP_CLD, 8'h00}, 1'b0, '0},
		'{'{OP_INC, 8'hFF}, 1'b0, '0},
		'{'{OP_DEC, 8'h00}, 1'b0, '0},
		'{'{OP_AND, 8'hF0}, 1'b0, '0},
		'{'{OP_ORA, 8'h0F}, 1'b0, '0},
		'{'{OP_EOR, 8'hFF}, 1'b0, '0},
		'{'{OP_STX, 8'h00}, 1'b0, '0},
		'{'{OP_STY, 8'hFF}, 1'b0, '0},
		'{'{OP_TAX, 8'h00}, 1'b0, '0},
		'{'{OP_TAY, 8'h00}, 1'b0, '0},
		'{'{OP_TSX, 8'h00}, 1'b0, '0},
		'{'{OP_TXA, 8'h00}, 1'b0, '0},
		'{'{OP_TXS, 8'h00}, 1'b0, '0},
		'{'{OP_TYA, 8'h00}, 1'b0, '0},
		'{'{KIND_SPARE_HIGH, 8'hFF}, 1'b0, '0},
		'{'{KIND_SPARE_LOW, 8'h00}, 1'b0, '0}
	};

	cpu6502_alu_execute_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	function automatic void set_nz(logic [7:0] v);
		arch.p[FLAG_N] = v[7];
		arch.p[FLAG_Z] = (v == 8'h00);
	endfunction

	function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
		logic [7:0] d;
		d = r - m;
		arch.p[FLAG_C] = (r >= m);
		arch.p[FLAG_Z] = (r == m);
		arch.p[FLAG_N] = d[7];
	endfunction

	function automatic out_t execute_op(in_t item);
		out_t       r;
		logic [7:0] m;
		logic [8:0] sum;
		logic       c;
		r = '0;
		m = item.operand;
		c = arch.p[FLAG_C];
		case (item.kind)
		OP_ADC, OP_SBC: begin
			if (item.kind == OP_SBC)
				m = ~m;
			sum = {1'b0, arch.a} + {1'b0, m} + {8'd0, c};
			arch.p[FLAG_V] = ~(arch.a[7] ^ m[7]) & (arch.a[7] ^ sum[7]);
			arch.p[FLAG_C] = sum[8];
			arch.a = sum[7:0];
			set_nz(arch.a);
		end
		OP_AND: begin arch.a = arch.a & m; set_nz(arch.a); end
		OP_ORA: begin arch.a = arch.a | m; set_nz(arch.a); end
		OP_EOR: begin arch.a = arch.a ^ m; set_nz(arch.a); end
		OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
			case (item.kind)
			OP_ASL: r.result_byte = {m[6:0], 1'b0};
			OP_LSR: r.result_byte = {1'b0, m[7:1]};
			OP_ROL: r.result_byte = {m[6:0], c};
			default: r.result_byte = {c, m[7:1]};
			endcase
			arch.p[FLAG_C] = (item.kind == OP_ASL || item.kind == OP_ROL) ? m[7] : m[0];
			set_nz(r.result_byte);
			r.write_back = 1'b1;
		end
		OP_BCC: r.branch_taken = ~arch.p[FLAG_C];
		OP_BCS: r.branch_taken = arch.p[FLAG_C];
		OP_BEQ: r.branch_taken = arch.p[FLAG_Z];
		OP_BMI: r.branch_taken = arch.p[FLAG_N];
		OP_BPL: r.branch_taken = ~arch.p[FLAG_N];
		OP_BVC: r.branch_taken = ~arch.p[FLAG_V];
		OP_BVS: r.branch_taken = arch.p[FLAG_V];
		OP_BIT: begin
			arch.p[FLAG_N] = m[7];
			arch.p[FLAG_V] = m[6];
			arch.p[FLAG_Z] = ((arch.a & m) == 8'h00);
		end
		OP_CLC: arch.p[FLAG_C] = 1'b0;
		OP_CLD: arch.p[FLAG_D] = 1'b0;
		OP_CLI: arch.p[FLAG_I] = 1'b0;
		OP_CLV: arch.p[FLAG_V] = 1'b0;
		OP_SEC: arch.p[FLAG_C] = 1'b1;
		OP_SED: arch.p[FLAG_D] = 1'b1;
		OP_SEI: arch.p[FLAG_I] = 1'b1;
		OP_CMP: compare_reg(arch.a, m);
		OP_CPX: compare_reg(arch.x, m);
		OP_CPY: compare_reg(arch.y, m);
		OP_DEC, OP_INC: begin
			r.result_byte = (item.kind == OP_INC) ? m + 8'd1 : m - 8'd1;
			set_nz(r.result_byte);
			r.write_back = 1'b1;
		end
		OP_DEX: begin arch.x = arch.x - 8'd1; set_nz(arch.x); end
		OP_DEY: begin arch.y = arch.y - 8'd1; set_nz(arch.y); end
		OP_INX: begin arch.x = arch.x + 8'd1; set_nz(arch.x); end
		OP_INY: begin arch.y = arch.y + 8'd1; set_nz(arch.y); end
		OP_LDA: begin arch.a = m; set_nz(arch.a); end
		OP_LDX: begin arch.x = m; set_nz(arch.x); end
		OP_LDY: begin arch.y = m; set_nz(arch.y); end
		OP_STA: begin r.result_byte = arch.a; r.write_back = 1'b1; end
		OP_STX: begin r.result_byte = arch.x; r.write_back = 1'b1; end
		OP_STY: begin r.result_byte = arch.y; r.write_back = 1'b1; end
		OP_TAX: begin arch.x = arch.a; set_nz(arch.x); end
		OP_TAY: begin arch.y = arch.a; set_nz(arch.y); end
		OP_TSX: begin arch.x = arch.sp; set_nz(arch.x); end
		OP_TXA: begin arch.a = arch.x; set_nz(arch.a); end
		OP_TXS: arch.sp = arch.x;
		OP_TYA: begin arch.a = arch.y; set_nz(arch.a); end
		default: ;
		endcase
		r.accumulator   = arch.a;
		r.index_x       = arch.x;
		r.index_y       = arch.y;
		r.stack_pointer = arch.sp;
		r.status_flags  = arch.p;
		return r;
	endfunction

	task automatic check_result(out_t got, out_t want);
		if (got.result_byte !== want.result_byte) begin
			$error("result_byte: expected %02h, got %02h", want.result_byte, got.result_byte);
			failures++;
		end
		if (got.write_back !== want.write_back) begin
			$error("write_back: expected %0b, got %0b", want.write_back, got.write_back);
			failures++;
		end
		if (got.branch_taken !== want.branch_taken) begin
			$error("branch_taken: expected %0b, got %0b", want.branch_taken, got.branch_taken);
			failures++;
		end
		if (got.accumulator !== want.accumulator) begin
			$error("accumulator: expected %02h, got %02h", want.accumulator, got.accumulator);
			failures++;
		end
		if (got.index_x !== want.index_x) begin
			$error("index_x: expected %02h, got %02h", want.index_x, got.index_x);
			failures++;
		end
		if (got.index_y !== want.index_y) begin
			$error("index_y: expected %02h, got %02h", want.index_y, got.index_y);
			failures++;
		end
		if (got.stack_pointer !== want.stack_pointer) begin
			$error("stack_pointer: expected %02h, got %02h",
				want.stack_pointer, got.stack_pointer);
			failures++;
		end
		if (got.status_flags !== want.status_flags) begin
			$error("status_flags: expected %02h, got %02h", want.status_flags, got.status_flags);
			failures++;
		end
	endtask

	// enter and leave on a rising edge; valid stays high across back-to-back transfers
	task automatic send_op(in_t item, logic typed, out_t want);
		int   gap;
		out_t predicted;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		predicted = execute_op(item);
		pending_results.push_back(typed ? want : predicted);
		ops_sent++;
	endtask

	task automatic send_random_ops(int count);
		in_t item;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 88)
				item.kind = 6'($urandom_range(45));
			else
				item.kind = 6'($urandom_range(KIND_SPARE_HIGH, KIND_SPARE_LOW));
			if ($urandom_range(99) < 20) begin
				case ($urandom_range(4))
				0: item.operand = 8'h00;
				1: item.operand = 8'hFF;
				2: item.operand = 8'h7F;
				3: item.operand = 8'h80;
				default: item.operand = 8'h01;
				endcase
			end else begin
				item.operand = 8'($urandom_range(255));
			end
			send_op(item, 1'b0, '0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("cpu6502_alu_execute_core verification failed");
		$finish;
	end

	// receiver: check, then drop ready at random or for a long hold every 500 results
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: nothing pending, got %h", out_data);
					failures++;
				end else begin
					check_result(out_data, pending_results.pop_front());
				end
				results_seen++;
				branches_taken += out_data.branch_taken;
				writes_back    += out_data.write_back;
				if (results_seen % 500 == 250)
					hold_left = 60;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		arch.a  = 8'h00;
		arch.x  = 8'h00;
		arch.y  = 8'h00;
		arch.sp = SP_RESET;
		arch.p  = STATUS_RESET;
		failures       = 0;
		ops_sent       = 0;
		results_seen   = 0;
		branches_taken = 0;
		writes_back    = 0;
		hold_left      = 0;
		send_idle_pct  = 34;
		recv_idle_pct  = 45;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_op(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		send_random_ops(480);

		send_idle_pct = 45;
		recv_idle_pct = 34;
		send_random_ops(480);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_ops(490);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d operations (%0d from the directed table) through three idling patterns",
			ops_sent, directed_rows.size());
		$display("Checked %0d results: %0d branches taken, %0d write-backs, %0d mismatches",
			results_seen, branches_taken, writes_back, failures);
		if (failures == 0)
			$display("cpu6502_alu_execute_core verification clean");
		else
			$display("cpu6502_alu_execute_core verification failed");
		$finish;
	end

endmodule
